[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the CRC engine blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[rtl/mwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-width CRC package
// Types, constants and the byte-wide CRC update shared by the engine.
// ----------------------------------------------------------------------------
package mwc_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam logic [CNT_W-1:0] BLOCK_CNT = CNT_W'(BLOCK_BYTES);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] POLY_RESET = 16'h1021;

  typedef enum logic [1:0] {
    MODE_CRC8  = 2'd0,
    MODE_CRC7  = 2'd1,
    MODE_CRC16 = 2'd2,
    MODE_BLOCK = 2'd3
  } mwc_mode_t;

  typedef enum logic {
    CFG_MODE = 1'b0,
    CFG_POLY = 1'b1
  } mwc_cfg_t;

  typedef enum logic {
    ST_RUN = 1'b0,
    ST_PAD = 1'b1
  } mwc_state_t;

  // One queued word, with the configuration that was live when it arrived.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    mwc_mode_t   mode;
    logic [15:0] poly;
  } mwc_item_t;

  // Shifts one byte, MSB first, into a CRC of the width that the mode selects.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input mwc_mode_t   mode,
                                           input logic [15:0] poly);
    logic [15:0] mask;
    logic [15:0] crc;
    logic        top;
    logic        fb;
    unique case (mode) inside
      MODE_CRC8:              mask = 16'h00FF;
      MODE_CRC7:              mask = 16'h007F;
      MODE_CRC16, MODE_BLOCK: mask = 16'hFFFF;
      default:                mask = 16'hFFFF;
    endcase
    crc = crc_in & mask;
    for (int b = 7; b >= 0; b--) begin
      unique case (mode) inside
        MODE_CRC8:              top = crc[7];
        MODE_CRC7:              top = crc[6];
        MODE_CRC16, MODE_BLOCK: top = crc[15];
        default:                top = crc[15];
      endcase
      fb  = top ^ data[b];
      crc = (crc << 1) & mask;
      if (fb) begin
        crc = crc ^ (poly & mask);
      end
    end
    return crc;
  endfunction

endpackage

[rtl/mwc_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// CRC engine front end
// Holds the configuration registers and queues incoming words together with
// the mode and polynomial that apply to them.
// ----------------------------------------------------------------------------
module mwc_front
  import mwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        q_valid,
  output mwc_item_t   q_item,
  input  logic        q_take
);

  mwc_mode_t   mode;
  logic [15:0] polynomial;

  mwc_item_t   entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic        accept;
  logic        take;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign accept  = push && !full;
  assign take    = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CRC16;
      polynomial <= POLY_RESET;
    end else if (cfg_write) begin
      unique case (mwc_cfg_t'(cfg_index))
        CFG_MODE: mode       <= mwc_mode_t'(cfg_data[1:0]);
        CFG_POLY: polynomial <= cfg_data;
        default:  mode       <= mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= '{data: data_byte, last: last, mode: mode, poly: polynomial};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (accept && !take) begin
        count <= count + 1'b1;
      end else if (take && !accept) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > QCNT_W'(QUEUE_DEPTH))
  `ASSERT_AT(a_count_up, clk, rst, (accept && !take) |=> (count == $past(count) + 1'b1))
  `ASSERT_AT(a_count_down, clk, rst, (take && !accept) |=> (count == $past(count) - 1'b1))

endmodule

[rtl/mwc_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// CRC engine back end
// Folds one queued word per cycle, unless padding or held for the result slot, into
// the running CRC, pads fixed blocks with zero bytes and holds the final CRC till popped.
// ----------------------------------------------------------------------------
module mwc_back
  import mwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  mwc_item_t   q_item,
  output logic        q_take,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] crc_value
);

  mwc_state_t       state;
  mwc_state_t       state_next;
  logic [15:0]      crc_reg;
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      pad_poly;
  logic             res_valid;
  logic [15:0]      res_crc;

  logic             out_free;
  logic             feed_ok;
  logic [15:0]      crc_fed;
  logic [15:0]      crc_run;
  logic [CNT_W-1:0] cnt_inc;
  logic             need_pad;
  logic [15:0]      pad_crc;
  logic             pad_done;
  logic             take;
  logic             pad_step;
  logic             res_load;

  assign out_free  = !res_valid || pop;
  assign empty     = !res_valid;
  assign crc_value = res_crc;

  // Datapath: one byte through the CRC per cycle, either a real word or a pad byte.
  always_comb begin
    crc_fed  = crc_feed(crc_reg, q_item.data, q_item.mode, q_item.poly);
    feed_ok  = (q_item.mode != MODE_BLOCK) || (byte_count < BLOCK_CNT);
    crc_run  = feed_ok ? crc_fed : crc_reg;
    cnt_inc  = (byte_count < BLOCK_CNT) ? byte_count + 1'b1 : byte_count;
    need_pad = q_item.last && (q_item.mode == MODE_BLOCK) && (cnt_inc < BLOCK_CNT);
    pad_crc  = crc_feed(crc_reg, 8'h00, MODE_BLOCK, pad_poly);
    pad_done = ((byte_count + 1'b1) == BLOCK_CNT);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (take && need_pad) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pad_step && pad_done) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // A last word only leaves the queue when the result slot can take its CRC.
  always_comb begin
    take     = 1'b0;
    pad_step = 1'b0;
    unique case (state)
      ST_RUN:  take     = q_valid && (!q_item.last || out_free);
      ST_PAD:  pad_step = !pad_done || out_free;
      default: take     = 1'b0;
    endcase
    res_load = (take && q_item.last && !need_pad) || (pad_step && pad_done);
    q_take   = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      crc_reg    <= '0;
      byte_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        if (q_item.last && !need_pad) begin
          crc_reg    <= '0;
          byte_count <= '0;
        end else begin
          crc_reg    <= crc_run;
          byte_count <= cnt_inc;
        end
      end else if (pad_step) begin
        if (pad_done) begin
          crc_reg    <= '0;
          byte_count <= '0;
        end else begin
          crc_reg    <= pad_crc;
          byte_count <= byte_count + 1'b1;
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && need_pad) begin
      pad_poly <= q_item.poly;
    end
    if (res_load) begin
      res_crc <= take ? crc_run : pad_crc;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, byte_count > BLOCK_CNT)
  `ASSERT_NEVER(a_pad_count, clk, rst, (state == ST_PAD) && (byte_count >= BLOCK_CNT))
  `ASSERT_NEVER(a_no_take_in_pad, clk, rst, (state == ST_PAD) && q_take)
  `ASSERT_AT(a_no_overwrite, clk, rst, res_load |-> out_free)

endmodule

[rtl/multi_width_crc_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-width CRC engine
// MSB-first CRC-8, CRC-7, CRC-16 or zero-padded block CRC-16 over bytes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the byte-wide CRC update in the back end,
//   except while padding runs or a last word waits for the result slot.
// Result: the last byte passes the queue and the back end, which registers its CRC;
//   in block mode one zero byte per missing byte (BLOCK_BYTES - n) is fed first.
// A four-word queue lets input continue while padding runs or a result waits.
// Reset (rst, synchronous): queue and result emptied, CRC and count cleared,
//   mode set to CRC-16 and polynomial to 0x1021.
module multi_width_crc_engine
  import mwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] crc_value,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic      q_valid;
  logic      q_take;
  mwc_item_t q_item;

  mwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take)
  );

  mwc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .empty     (empty),
    .pop       (pop),
    .crc_value (crc_value)
  );

endmodule

[tb/sv/multi_width_crc_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-width CRC engine testbench
// Streams byte words through the engine in all four CRC modes and compares
// every CRC against a cycle-free prediction kept in the bench. Configuration
// changes happen only while the engine is idle, some of them in mid-message.
// ----------------------------------------------------------------------------
module multi_width_crc_engine_test;
  import mwc_pkg::*;

  localparam int TOTAL_WORDS = 1850;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] crc_value;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  multi_width_crc_engine dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last      (last),
    .empty     (empty),
    .pop       (pop),
    .crc_value (crc_value),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Bench copy of the engine's configuration and running state.
  mwc_mode_t   cur_mode = MODE_CRC16;
  logic [15:0] cur_poly = POLY_RESET;
  logic [15:0] run_crc = 16'h0000;
  int          run_count = 0;

  byte_word_t  tx_bytes[$];
  logic [15:0] awaited_crcs[$];
  byte_word_t  next_word;
  int          queued_cnt = 0;
  int          accepted_cnt = 0;
  int          errors = 0;
  int          send_wait = 0;
  bit          send_burst = 1'b0;
  int          take_wait = 0;
  bit          take_burst = 1'b0;
  int          stall_cycles = 0;

  function automatic int crc_bits(mwc_mode_t m);
    case (m)
      MODE_CRC8: return 8;
      MODE_CRC7: return 7;
      default:   return 16;
    endcase
  endfunction

  function automatic logic [15:0] shift_byte(logic [15:0] crc, logic [7:0] b, int w,
                                             logic [15:0] poly);
    logic [15:0] mask;
    logic        fb;
    mask = 16'hFFFF >> (16 - w);
    crc = crc & mask;
    for (int i = 7; i >= 0; i--) begin
      fb = crc[w-1] ^ b[i];
      crc = (crc << 1) & mask;
      if (fb) begin
        crc = crc ^ (poly & mask);
      end
    end
    return crc;
  endfunction

  // Advances the predicted state by one accepted word; a last word yields a CRC.
  task automatic absorb_byte(logic [7:0] d, logic l);
    int          w;
    logic [15:0] c;
    w = crc_bits(cur_mode);
    c = run_crc & (16'hFFFF >> (16 - w));
    if (cur_mode != MODE_BLOCK || run_count < BLOCK_BYTES) begin
      c = shift_byte(c, d, w, cur_poly);
    end
    if (run_count < BLOCK_BYTES) begin
      run_count++;
    end
    if (!l) begin
      run_crc = c;
    end else begin
      if (cur_mode == MODE_BLOCK) begin
        for (int n = run_count; n < BLOCK_BYTES; n++) begin
          c = shift_byte(c, 8'h00, w, cur_poly);
        end
      end
      awaited_crcs.push_back(c);
      run_crc = 16'h0000;
      run_count = 0;
    end
  endtask

  // Sender: one word per handshake, with a random wait drawn for every word.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        accepted_cnt++;
        absorb_byte(data_byte, last);
      end
      if (push && full) begin
        // Hold the word until the engine takes it.
      end else if (tx_bytes.size() != 0 && send_wait == 0) begin
        next_word = tx_bytes.pop_front();
        data_byte <= next_word.data;
        last <= next_word.last;
        push <= 1'b1;
        if ($urandom_range(0, 39) == 0) begin
          send_burst = !send_burst;
        end
        send_wait = send_burst ? 0 : $urandom_range(0, 13);
      end else begin
        if (send_wait > 0) begin
          send_wait--;
        end
        push <= 1'b0;
      end
    end
  end

  // Receiver: checks each CRC word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_crcs.size() == 0) begin
          $display("%0t: unexpected crc_value %h with nothing expected", $time, crc_value);
          errors++;
        end else begin
          if (crc_value !== awaited_crcs[0]) begin
            $display("%0t: crc_value mismatch, expected %h, actual %h", $time,
                     awaited_crcs[0], crc_value);
            errors++;
          end
          void'(awaited_crcs.pop_front());
        end
        if ($urandom_range(0, 19) == 0) begin
          take_burst = !take_burst;
        end
        take_wait = take_burst ? 0 : $urandom_range(0, 13);
      end
      // The stall only runs down while a result is actually waiting.
      if (take_wait > 0) begin
        pop <= 1'b0;
        if (!empty) begin
          take_wait--;
        end
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic add_word(logic [7:0] d, logic l);
    tx_bytes.push_back('{data: d, last: l});
    queued_cnt++;
  endtask

  // A message of random bytes; when close is clear the message stays open.
  task automatic add_message(int len, bit close);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom_range(0, 255));
      endcase
      add_word(d, close && (i == len - 1));
    end
  endtask

  // Waits until every word is taken and every CRC has come back, then lets
  // the back end finish any open-message words still in flight.
  task automatic drain();
    while (accepted_cnt != queued_cnt || awaited_crcs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(mwc_cfg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_MODE) begin
      cur_mode = mwc_mode_t'(val[1:0]);
    end else begin
      cur_poly = val;
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [15:0] pick_poly();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h1021;
      3:       return 16'h8005;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int          msgs;
    int          len;
    logic [15:0] raw;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: CRC-16 with 0x1021, single-word and check-string messages.
    add_word(8'h00, 1'b1);
    add_word(8'hFF, 1'b1);
    for (int i = 0; i < 9; i++) begin
      add_word(8'h31 + 8'(i), i == 8);
    end
    drain();

    // CRC-8 at the data extremes.
    set_reg(CFG_MODE, {14'd0, MODE_CRC8});
    set_reg(CFG_POLY, 16'h0007);
    add_word(8'hFF, 1'b0);
    add_word(8'h00, 1'b1);
    add_word(8'hA5, 1'b1);
    drain();

    // CRC-7 message left open, then finished as CRC-16.
    set_reg(CFG_MODE, {14'd0, MODE_CRC7});
    set_reg(CFG_POLY, 16'h0009);
    add_word(8'h40, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h12, 1'b0);
    drain();
    set_reg(CFG_MODE, {14'd0, MODE_CRC16});
    add_word(8'h34, 1'b1);
    drain();

    // Block mode: a one-word block, then a polynomial change in mid-message.
    set_reg(CFG_MODE, {14'd0, MODE_BLOCK});
    set_reg(CFG_POLY, 16'h8005);
    add_word(8'h01, 1'b1);
    add_word(8'hAA, 1'b0);
    drain();
    set_reg(CFG_POLY, 16'hFFFF);
    add_word(8'h55, 1'b1);
    drain();

    // A block filled exactly, with no padding needed.
    set_reg(CFG_POLY, 16'h1021);
    add_message(BLOCK_BYTES, 1'b1);
    drain();

    // The count from CRC-16 mode carries into block mode, where the words
    // past the block are ignored and the last one still ends it.
    set_reg(CFG_MODE, {14'd0, MODE_CRC16});
    add_message(BLOCK_BYTES - 4, 1'b0);
    drain();
    set_reg(CFG_MODE, {14'd0, MODE_BLOCK});
    add_message(6, 1'b1);
    drain();

    while (queued_cnt < TOTAL_WORDS) begin
      case ($urandom_range(0, 3))
        0: set_reg(CFG_MODE, {14'd0, mwc_mode_t'($urandom_range(0, 3))});
        1: set_reg(CFG_POLY, pick_poly());
        default: begin
          set_reg(CFG_MODE, {14'd0, mwc_mode_t'($urandom_range(0, 3))});
          set_reg(CFG_POLY, pick_poly());
        end
      endcase
      // Now and then write an arbitrary value so every data bit toggles.
      if ($urandom_range(0, 7) == 0) begin
        raw = 16'($urandom_range(0, 65535));
        set_reg(CFG_MODE, raw);
      end
      msgs = $urandom_range(3, 12);
      for (int m = 0; m < msgs; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        add_message(len, 1'b1);
      end
      // Leave a message open so the next settings apply in mid-message.
      if ($urandom_range(0, 3) == 0) begin
        add_message($urandom_range(1, 6), 1'b0);
      end
      drain();
    end

    // Close any message still open.
    add_word(8'($urandom_range(0, 255)), 1'b1);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && awaited_crcs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/mwc_pkg.sv
rtl/mwc_front.sv
rtl/mwc_back.sv
rtl/multi_width_crc_engine.sv
tb/sv/multi_width_crc_engine_test.sv
